[sv/sitc_pkg.sv]
// ----------------------------------------------------------------------------
// sitc_pkg
// shared constants and types for the segment intersection test core
// ----------------------------------------------------------------------------
package sitc_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // number of orientation tests per segment pair
    localparam int NUM_TESTS = 4;

    // orientation codes
    typedef logic [1:0] t_orient;
    localparam t_orient ORIENT_COLLINEAR = 2'd0;
    localparam t_orient ORIENT_POS       = 2'd1;
    localparam t_orient ORIENT_NEG       = 2'd2;

endpackage

[sv/segment_intersection_test_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// line segment intersection by four orientation tests, four-stage pipeline
// ----------------------------------------------------------------------------
// Takes one request per cycle: two segments A and B as signed endpoints, and
// reports whether they intersect or touch. Four orientation tests (signs of
// exact cross products) decide the general case; a collinear triple then hits
// when the middle point lies in the closed bounding box of the other segment.
// With i_stall low the block sustains one request per clock; the multiply
// stage forms one product pair per test per cycle.
// Stages: coordinate differences and box compares, products, product
// difference sign, final decision into the output register. Each stage holds
// its own valid bit and advances when the stage after it is empty or moving,
// so bubbles close up and a new request is taken while a result waits.
// There is no state besides the pipeline; results come out in request order.
// ----------------------------------------------------------------------------
module segment_intersection_test_core #(
    parameter int COORD_WIDTH = sitc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_end_y,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_segments_cross
);

    localparam int NT = sitc_pkg::NUM_TESTS;
    // difference of two coordinates needs one extra bit
    localparam int DW = COORD_WIDTH + 1;
    // full product of two differences
    localparam int PW = 2 * DW;
    // difference of two products
    localparam int SW = PW + 1;

    // ------------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or when draining
    // ------------------------------------------------------------------
    logic w_rdy_out, w_rdy3, w_rdy2, w_rdy1;
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;

    assign w_rdy_out = !r_out_v || !i_stall;
    assign w_rdy3    = !r_s3_v  || w_rdy_out;
    assign w_rdy2    = !r_s2_v  || w_rdy3;
    assign w_rdy1    = !r_s1_v  || w_rdy2;
    assign o_stall   = !w_rdy1;

    // ------------------------------------------------------------------
    // triple selection: test k checks r against the line through p and q
    //   test 0: (a0, a1, b0)   test 1: (a0, a1, b1)
    //   test 2: (b0, b1, a0)   test 3: (b0, b1, a1)
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] w_px [NT];
    logic signed [COORD_WIDTH-1:0] w_py [NT];
    logic signed [COORD_WIDTH-1:0] w_qx [NT];
    logic signed [COORD_WIDTH-1:0] w_qy [NT];
    logic signed [COORD_WIDTH-1:0] w_rx [NT];
    logic signed [COORD_WIDTH-1:0] w_ry [NT];

    always_comb begin
        w_px[0] = i_seg_a_start_x; w_py[0] = i_seg_a_start_y;
        w_qx[0] = i_seg_a_end_x;   w_qy[0] = i_seg_a_end_y;
        w_rx[0] = i_seg_b_start_x; w_ry[0] = i_seg_b_start_y;

        w_px[1] = i_seg_a_start_x; w_py[1] = i_seg_a_start_y;
        w_qx[1] = i_seg_a_end_x;   w_qy[1] = i_seg_a_end_y;
        w_rx[1] = i_seg_b_end_x;   w_ry[1] = i_seg_b_end_y;

        w_px[2] = i_seg_b_start_x; w_py[2] = i_seg_b_start_y;
        w_qx[2] = i_seg_b_end_x;   w_qy[2] = i_seg_b_end_y;
        w_rx[2] = i_seg_a_start_x; w_ry[2] = i_seg_a_start_y;

        w_px[3] = i_seg_b_start_x; w_py[3] = i_seg_b_start_y;
        w_qx[3] = i_seg_b_end_x;   w_qy[3] = i_seg_b_end_y;
        w_rx[3] = i_seg_a_end_x;   w_ry[3] = i_seg_a_end_y;
    end

    // ------------------------------------------------------------------
    // stage 1: coordinate differences and bounding-box compares
    // cross term is (q.y-p.y)*(r.x-q.x) - (q.x-p.x)*(r.y-q.y)
    // ------------------------------------------------------------------
    logic signed [DW-1:0] n_s1_a [NT];
    logic signed [DW-1:0] n_s1_b [NT];
    logic signed [DW-1:0] n_s1_c [NT];
    logic signed [DW-1:0] n_s1_d [NT];
    logic [NT-1:0]        n_s1_box;

    logic signed [DW-1:0] r_s1_a [NT];
    logic signed [DW-1:0] r_s1_b [NT];
    logic signed [DW-1:0] r_s1_c [NT];
    logic signed [DW-1:0] r_s1_d [NT];
    logic [NT-1:0]        r_s1_box;

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            n_s1_a[k] = DW'(w_qy[k]) - DW'(w_py[k]);
            n_s1_b[k] = DW'(w_rx[k]) - DW'(w_qx[k]);
            n_s1_c[k] = DW'(w_qx[k]) - DW'(w_px[k]);
            n_s1_d[k] = DW'(w_ry[k]) - DW'(w_qy[k]);
            // r inside the closed box spanned by p and q
            n_s1_box[k] = (w_rx[k] >= w_px[k] || w_rx[k] >= w_qx[k]) &&
                          (w_rx[k] <= w_px[k] || w_rx[k] <= w_qx[k]) &&
                          (w_ry[k] >= w_py[k] || w_ry[k] >= w_qy[k]) &&
                          (w_ry[k] <= w_py[k] || w_ry[k] <= w_qy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_a   <= n_s1_a;
            r_s1_b   <= n_s1_b;
            r_s1_c   <= n_s1_c;
            r_s1_d   <= n_s1_d;
            r_s1_box <= n_s1_box;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: the two exact products of each test
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_s2_m1 [NT];
    logic signed [PW-1:0] r_s2_m2 [NT];
    logic [NT-1:0]        r_s2_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_v) begin
            for (int k = 0; k < NT; k++) begin
                r_s2_m1[k] <= PW'(r_s1_a[k]) * PW'(r_s1_b[k]);
                r_s2_m2[k] <= PW'(r_s1_c[k]) * PW'(r_s1_d[k]);
            end
            r_s2_box <= r_s1_box;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sign of the product difference as an orientation code
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  w_s3_diff [NT];
    sitc_pkg::t_orient     n_s3_ori  [NT];
    sitc_pkg::t_orient     r_s3_ori  [NT];
    logic [NT-1:0]         r_s3_box;

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            w_s3_diff[k] = SW'(r_s2_m1[k]) - SW'(r_s2_m2[k]);
            if (w_s3_diff[k] == '0) begin
                n_s3_ori[k] = sitc_pkg::ORIENT_COLLINEAR;
            end else if (w_s3_diff[k][SW-1]) begin
                n_s3_ori[k] = sitc_pkg::ORIENT_NEG;
            end else begin
                n_s3_ori[k] = sitc_pkg::ORIENT_POS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_s2_v) begin
            r_s3_ori <= n_s3_ori;
            r_s3_box <= r_s2_box;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: general case, else a collinear point inside the other box
    // ------------------------------------------------------------------
    logic n_cross;
    logic r_cross;

    always_comb begin
        n_cross = ((r_s3_ori[0] != r_s3_ori[1]) && (r_s3_ori[2] != r_s3_ori[3]));
        for (int k = 0; k < NT; k++) begin
            if (r_s3_ori[k] == sitc_pkg::ORIENT_COLLINEAR && r_s3_box[k]) begin
                n_cross = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && r_s3_v) begin
            r_cross <= n_cross;
        end
    end

    assign o_valid          = r_out_v;
    assign o_segments_cross = r_cross;

endmodule

[sv/sitc_checker.sv]
// ----------------------------------------------------------------------------
// sitc_checker
// port-level checks for the segment intersection test core
// ----------------------------------------------------------------------------
module sitc_checker #(
    parameter int COORD_WIDTH = sitc_pkg::COORD_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_start_x,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_start_y,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_start_x,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_start_y,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_segments_cross
);

    logic w_req_acc;
    logic w_shared_pt;

    assign w_req_acc   = i_valid && !o_stall;
    assign w_shared_pt = (i_seg_a_start_x == i_seg_b_start_x) &&
                         (i_seg_a_start_y == i_seg_b_start_y);

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_segments_cross))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a draining output never backs up the request side
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("request stalled while output can drain");

    // segments sharing a start point always touch, checked while i_stall stays low
    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc && w_shared_pt ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid && o_segments_cross)
        else $error("shared endpoint not reported as crossing");

endmodule

bind segment_intersection_test_core sitc_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_sitc_checker (.*);
